### design/tlik_pkg.sv
// ============================================================================
// Two-link inverse kinematics package
// Shared widths, payload types, codes and the arctangent table for the
// inverse kinematics pipeline.
// ============================================================================
package tlik_pkg;

    localparam int COORD_W       = 16;
    localparam int ANGLE_W       = 16;
    localparam int LEN_W         = 15;
    localparam int CORDIC_STAGES = 16;
    localparam int DIV_STEPS     = 15;
    localparam int SQRT_STEPS    = 15;
    localparam int REM_W         = 33;
    localparam int DEN_W         = 31;
    localparam int RAD_W         = 30;
    localparam int CW            = 50;
    localparam int ZW            = 34;
    localparam int LANES         = 3;

    localparam logic [1:0] REACH_OK   = 2'd0;
    localparam logic [1:0] REACH_FAR  = 2'd1;
    localparam logic [1:0] REACH_NEAR = 2'd2;

    localparam logic [1:0] REG_LINK1    = 2'd0;
    localparam logic [1:0] REG_LINK2    = 2'd1;
    localparam logic [1:0] REG_SHOULDER = 2'd2;
    localparam logic [1:0] REG_ELBOW    = 2'd3;

    localparam logic [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } target_t;

    typedef struct packed {
        logic [1:0]                reach_status;
        logic                      first_valid;
        logic signed [ANGLE_W-1:0] first_shoulder;
        logic signed [ANGLE_W-1:0] first_elbow;
        logic                      second_valid;
        logic signed [ANGLE_W-1:0] second_shoulder;
        logic signed [ANGLE_W-1:0] second_elbow;
    } result_t;

    // Per-request data that rides along the divider and root chains.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [1:0]                status;
        logic                      neg;
        logic                      den_zero;
        logic signed [15:0]        c;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t [LANES-1:0] lane;
        logic [1:0]               status;
    } cordic_bus_t;

    // atan(2^-i) in Q.30, truncated.
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 31'h3243F6A8;
            5'd1:    return 31'h1DAC6705;
            5'd2:    return 31'h0FADBAFC;
            5'd3:    return 31'h07F56EA6;
            5'd4:    return 31'h03FEAB76;
            5'd5:    return 31'h01FFD55B;
            5'd6:    return 31'h00FFFAAA;
            5'd7:    return 31'h007FFF55;
            5'd8:    return 31'h003FFFEA;
            5'd9:    return 31'h001FFFFD;
            5'd10:   return 31'h000FFFFF;
            5'd11:   return 31'h0007FFFF;
            5'd12:   return 31'h0003FFFF;
            5'd13:   return 31'h0001FFFF;
            5'd14:   return 31'h0000FFFF;
            5'd15:   return 31'h00007FFF;
            5'd16:   return 31'h00003FFF;
            5'd17:   return 31'h00001FFF;
            5'd18:   return 31'h00000FFF;
            5'd19:   return 31'h000007FF;
            5'd20:   return 31'h000003FF;
            5'd21:   return 31'h000001FF;
            5'd22:   return 31'h000000FF;
            5'd23:   return 31'h0000007F;
            5'd24:   return 31'h0000003F;
            5'd25:   return 31'h0000001F;
            5'd26:   return 31'h0000000F;
            5'd27:   return 31'h00000007;
            5'd28:   return 31'h00000003;
            5'd29:   return 31'h00000001;
            default: return 31'h00000000;
        endcase
    endfunction

endpackage

### design/tlik_div_cell.sv
// ============================================================================
// Divider cell
// One restoring division step: compares the partial remainder with the
// divisor and shifts one quotient bit in.
// ============================================================================
module tlik_div_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [tlik_pkg::DEN_W-1:0]   den,
    input  logic                         prev_valid,
    input  logic [tlik_pkg::REM_W-1:0]   prev_rem,
    input  logic [tlik_pkg::DIV_STEPS-1:0] prev_quo,
    input  tlik_pkg::side_t              prev_side,
    output logic                         valid_reg,
    output logic [tlik_pkg::REM_W-1:0]   rem_reg,
    output logic [tlik_pkg::DIV_STEPS-1:0] quo_reg,
    output tlik_pkg::side_t              side_reg
);

    logic [tlik_pkg::REM_W-1:0]     diff;
    logic                           take;
    logic [tlik_pkg::REM_W-1:0]     rem_next;
    logic [tlik_pkg::DIV_STEPS-1:0] quo_next;

    always_comb
    begin
        take     = prev_rem >= tlik_pkg::REM_W'(den);
        diff     = take ? prev_rem - tlik_pkg::REM_W'(den) : prev_rem;
        rem_next = {diff[tlik_pkg::REM_W-2:0], 1'b0};
        quo_next = {prev_quo[tlik_pkg::DIV_STEPS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= prev_side;
        end
    end

endmodule

### design/tlik_sqrt_cell.sv
// ============================================================================
// Square root cell
// One digit step of the bit-by-bit integer square root.
// ============================================================================
module tlik_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [3:0]                 stage,
    input  logic                       prev_valid,
    input  logic [tlik_pkg::RAD_W-1:0] prev_rad,
    input  logic [tlik_pkg::RAD_W-1:0] prev_root,
    input  tlik_pkg::side_t            prev_side,
    output logic                       valid_reg,
    output logic [tlik_pkg::RAD_W-1:0] rad_reg,
    output logic [tlik_pkg::RAD_W-1:0] root_reg,
    output tlik_pkg::side_t            side_reg
);

    logic [4:0]                 shamt;
    logic [tlik_pkg::RAD_W-1:0] bitv;
    logic [tlik_pkg::RAD_W-1:0] trial;
    logic [tlik_pkg::RAD_W-1:0] rad_next;
    logic [tlik_pkg::RAD_W-1:0] root_next;

    always_comb
    begin
        shamt = 5'd28 - {stage, 1'b0};
        bitv  = tlik_pkg::RAD_W'(1) << shamt;
        trial = prev_root + bitv;
        if (prev_rad >= trial)
        begin
            rad_next  = prev_rad - trial;
            root_next = (prev_root >> 1) + bitv;
        end
        else
        begin
            rad_next  = prev_rad;
            root_next = prev_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            side_reg <= prev_side;
        end
    end

endmodule

### design/tlik_cordic_cell.sv
// ============================================================================
// CORDIC cell
// One vectoring micro-rotation applied to each of the three angle lanes.
// ============================================================================
module tlik_cordic_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [4:0]            stage,
    input  logic                  prev_valid,
    input  tlik_pkg::cordic_bus_t prev_bus,
    output logic                  valid_reg,
    output tlik_pkg::cordic_bus_t bus_reg
);

    tlik_pkg::cordic_bus_t       bus_next;
    logic signed [tlik_pkg::CW-1:0] xs [tlik_pkg::LANES];
    logic signed [tlik_pkg::CW-1:0] ys [tlik_pkg::LANES];
    logic signed [tlik_pkg::ZW-1:0] step;

    always_comb
    begin
        bus_next = prev_bus;
        step     = $signed({3'b000, tlik_pkg::atan_q30(stage)});
        for (int l = 0; l < tlik_pkg::LANES; l++)
        begin
            xs[l] = prev_bus.lane[l].x >>> stage;
            ys[l] = prev_bus.lane[l].y >>> stage;
            // A non-negative y rotates clockwise toward the x axis.
            if (!prev_bus.lane[l].y[tlik_pkg::CW-1])
            begin
                bus_next.lane[l].x = prev_bus.lane[l].x + ys[l];
                bus_next.lane[l].y = prev_bus.lane[l].y - xs[l];
                bus_next.lane[l].z = prev_bus.lane[l].z + step;
            end
            else
            begin
                bus_next.lane[l].x = prev_bus.lane[l].x - ys[l];
                bus_next.lane[l].y = prev_bus.lane[l].y + xs[l];
                bus_next.lane[l].z = prev_bus.lane[l].z - step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bus_reg <= bus_next;
        end
    end

endmodule

### design/two_link_planar_inverse_kinematics_core.sv
// ============================================================================
// Two-link planar inverse kinematics core
// Reach check, cosine law division, square root and three CORDIC atan2
// lanes; the divider, square root and CORDIC are chains of pipeline cells.
// ============================================================================
// Throughput: one request per cycle; the 15-cell divider, 15-cell square root
// and 16-cell CORDIC chains each advance one step per cycle, except that the
// whole pipeline stalls as one while a finished result is held.
// Reset clears every stage valid bit and loads the register defaults.
module two_link_planar_inverse_kinematics_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              target_valid,
    output logic              target_stall,
    input  tlik_pkg::target_t target,
    output logic              result_valid,
    input  logic              result_stall,
    output tlik_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LW = tlik_pkg::LEN_W;

    // ---------------- configuration ----------------
    logic [LW-1:0] link1_reg, link2_reg, shoulder_reg, elbow_reg;
    logic [31:0]   far_reg;
    logic [29:0]   near_reg;
    logic [30:0]   sq_sum_reg;
    logic [tlik_pkg::DEN_W-1:0] den_reg;
    logic [LW:0]   len_sum;
    logic [LW-1:0] len_diff;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link1_reg    <= 15'd4096;
            link2_reg    <= 15'd4096;
            shoulder_reg <= 15'd19302;
            elbow_reg    <= 15'd19302;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                tlik_pkg::REG_LINK1:    link1_reg    <= pwdata[LW-1:0];
                tlik_pkg::REG_LINK2:    link2_reg    <= pwdata[LW-1:0];
                tlik_pkg::REG_SHOULDER: shoulder_reg <= pwdata[LW-1:0];
                tlik_pkg::REG_ELBOW:    elbow_reg    <= pwdata[LW-1:0];
                default:                link1_reg    <= link1_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tlik_pkg::REG_LINK1:    prdata = {17'b0, link1_reg};
            tlik_pkg::REG_LINK2:    prdata = {17'b0, link2_reg};
            tlik_pkg::REG_SHOULDER: prdata = {17'b0, shoulder_reg};
            tlik_pkg::REG_ELBOW:    prdata = {17'b0, elbow_reg};
            default:                prdata = 32'b0;
        endcase
    end

    assign len_sum  = {1'b0, link1_reg} + {1'b0, link2_reg};
    assign len_diff = (link1_reg > link2_reg) ? link1_reg - link2_reg
                                              : link2_reg - link1_reg;

    // Quantities that depend on the link lengths alone.
    always_ff @(posedge clk)
    begin
        far_reg    <= 32'(len_sum) * 32'(len_sum);
        near_reg   <= 30'(len_diff) * 30'(len_diff);
        sq_sum_reg <= 31'(30'(link1_reg) * 30'(link1_reg))
                    + 31'(30'(link2_reg) * 30'(link2_reg));
        den_reg    <= {30'(link1_reg) * 30'(link2_reg), 1'b0};
    end

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic en;

    assign en           = !(out_valid_reg && result_stall);
    assign target_stall = !en;
    assign result_valid = out_valid_reg;

    // ---------------- front stages ----------------
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [15:0] s0_x_reg, s0_y_reg, s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg;
    logic [15:0] ux, uy;
    logic [30:0] ux2_reg, uy2_reg;
    logic [31:0] r2_reg;
    logic [31:0] r2_next;
    logic signed [32:0] num;
    logic [1:0] status;
    logic [tlik_pkg::REM_W-1:0] s3_rem_reg;
    tlik_pkg::side_t s3_side_reg, s3_side_next;

    assign ux = s0_x_reg[15] ? 16'(-s0_x_reg) : 16'(s0_x_reg);
    assign uy = s0_y_reg[15] ? 16'(-s0_y_reg) : 16'(s0_y_reg);
    assign r2_next = 32'(ux2_reg) + 32'(uy2_reg);

    always_comb
    begin
        num = $signed({1'b0, r2_reg}) - $signed({2'b0, sq_sum_reg});
        if (r2_reg > far_reg)
        begin
            status = tlik_pkg::REACH_FAR;
        end
        else if (r2_reg < 32'(near_reg))
        begin
            status = tlik_pkg::REACH_NEAR;
        end
        else
        begin
            status = tlik_pkg::REACH_OK;
        end
        s3_side_next.x        = s2_x_reg;
        s3_side_next.y        = s2_y_reg;
        s3_side_next.status   = status;
        s3_side_next.neg      = num[32];
        s3_side_next.den_zero = den_reg == '0;
        s3_side_next.c        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= target_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg    <= target.target_x;
            s0_y_reg    <= target.target_y;
            ux2_reg     <= 31'(32'(ux) * 32'(ux));
            uy2_reg     <= 31'(32'(uy) * 32'(uy));
            s1_x_reg    <= s0_x_reg;
            s1_y_reg    <= s0_y_reg;
            r2_reg      <= r2_next;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s3_rem_reg  <= num[32] ? 33'(-num) : 33'(num);
            s3_side_reg <= s3_side_next;
        end
    end

    // ---------------- divider chain ----------------
    logic                           div_valid [tlik_pkg::DIV_STEPS+1];
    logic [tlik_pkg::REM_W-1:0]     div_rem   [tlik_pkg::DIV_STEPS+1];
    logic [tlik_pkg::DIV_STEPS-1:0] div_quo   [tlik_pkg::DIV_STEPS+1];
    tlik_pkg::side_t                div_side  [tlik_pkg::DIV_STEPS+1];

    assign div_valid[0] = s3_valid_reg;
    assign div_rem[0]   = s3_rem_reg;
    assign div_quo[0]   = '0;
    assign div_side[0]  = s3_side_reg;

    for (genvar k = 0; k < tlik_pkg::DIV_STEPS; k++)
    begin : g_div
        tlik_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .den        (den_reg),
            .prev_valid (div_valid[k]),
            .prev_rem   (div_rem[k]),
            .prev_quo   (div_quo[k]),
            .prev_side  (div_side[k]),
            .valid_reg  (div_valid[k+1]),
            .rem_reg    (div_rem[k+1]),
            .quo_reg    (div_quo[k+1]),
            .side_reg   (div_side[k+1])
        );
    end

    // ---------------- cosine and radicand ----------------
    logic pc_valid_reg, pa_valid_reg;
    tlik_pkg::side_t pc_side_reg, pc_side_next, pa_side_reg;
    logic [14:0] q_clamped;
    logic [31:0] c_sq;
    logic [tlik_pkg::RAD_W-1:0] pa_rad_reg;

    always_comb
    begin
        q_clamped = (div_quo[tlik_pkg::DIV_STEPS] > 15'd16384)
                  ? 15'd16384 : div_quo[tlik_pkg::DIV_STEPS];
        pc_side_next = div_side[tlik_pkg::DIV_STEPS];
        if (pc_side_next.den_zero)
        begin
            pc_side_next.c = 16'sd16384;
        end
        else if (pc_side_next.neg)
        begin
            pc_side_next.c = -$signed({1'b0, q_clamped});
        end
        else
        begin
            pc_side_next.c = $signed({1'b0, q_clamped});
        end
    end

    assign c_sq = 32'(pc_side_reg.c) * 32'(pc_side_reg.c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_valid_reg <= 1'b0;
            pa_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pc_valid_reg <= div_valid[tlik_pkg::DIV_STEPS];
            pa_valid_reg <= pc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_side_reg <= pc_side_next;
            pa_side_reg <= pc_side_reg;
            pa_rad_reg  <= tlik_pkg::RAD_W'(32'h1000_0000 - c_sq);
        end
    end

    // ---------------- square root chain ----------------
    logic                       sq_valid [tlik_pkg::SQRT_STEPS+1];
    logic [tlik_pkg::RAD_W-1:0] sq_rad   [tlik_pkg::SQRT_STEPS+1];
    logic [tlik_pkg::RAD_W-1:0] sq_root  [tlik_pkg::SQRT_STEPS+1];
    tlik_pkg::side_t            sq_side  [tlik_pkg::SQRT_STEPS+1];

    assign sq_valid[0] = pa_valid_reg;
    assign sq_rad[0]   = pa_rad_reg;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = pa_side_reg;

    for (genvar k = 0; k < tlik_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        tlik_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .stage      (4'(k)),
            .prev_valid (sq_valid[k]),
            .prev_rad   (sq_rad[k]),
            .prev_root  (sq_root[k]),
            .prev_side  (sq_side[k]),
            .valid_reg  (sq_valid[k+1]),
            .rad_reg    (sq_rad[k+1]),
            .root_reg   (sq_root[k+1]),
            .side_reg   (sq_side[k+1])
        );
    end

    // ---------------- shoulder operands ----------------
    logic k1_valid_reg, k2_valid_reg, k3_valid_reg, k4_valid_reg;
    tlik_pkg::side_t k1_side_reg, k2_side_reg, k3_side_reg, k4_side_reg;
    logic signed [15:0] k1_s_reg, k2_s_reg, k3_s_reg, k4_s_reg;
    logic signed [31:0] d2c_reg, kc_reg;
    logic signed [31:0] ks_reg;
    logic [29:0]        d2s_reg;
    logic signed [47:0] yk1_reg, xks_reg, xk1_reg, yks_reg;
    logic signed [47:0] y1_reg, x1_reg, y2_reg, x2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_valid_reg <= 1'b0;
            k2_valid_reg <= 1'b0;
            k3_valid_reg <= 1'b0;
            k4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k1_valid_reg <= sq_valid[tlik_pkg::SQRT_STEPS];
            k2_valid_reg <= k1_valid_reg;
            k3_valid_reg <= k2_valid_reg;
            k4_valid_reg <= k3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_side_reg <= sq_side[tlik_pkg::SQRT_STEPS];
            k1_s_reg    <= $signed(sq_root[tlik_pkg::SQRT_STEPS][15:0]);
            d2c_reg     <= $signed({1'b0, link2_reg}) * sq_side[tlik_pkg::SQRT_STEPS].c;
            d2s_reg     <= 30'(link2_reg) * 30'(sq_root[tlik_pkg::SQRT_STEPS][14:0]);

            k2_side_reg <= k1_side_reg;
            k2_s_reg    <= k1_s_reg;
            kc_reg      <= $signed({2'b0, link1_reg, 14'b0}) + d2c_reg;
            ks_reg      <= $signed({2'b0, d2s_reg});

            k3_side_reg <= k2_side_reg;
            k3_s_reg    <= k2_s_reg;
            yk1_reg     <= k2_side_reg.y * kc_reg;
            xks_reg     <= k2_side_reg.x * ks_reg;
            xk1_reg     <= k2_side_reg.x * kc_reg;
            yks_reg     <= k2_side_reg.y * ks_reg;

            k4_side_reg <= k3_side_reg;
            k4_s_reg    <= k3_s_reg;
            y1_reg      <= yk1_reg - xks_reg;
            x1_reg      <= xk1_reg + yks_reg;
            y2_reg      <= yk1_reg + xks_reg;
            x2_reg      <= xk1_reg - yks_reg;
        end
    end

    // ---------------- quadrant pre-rotation ----------------
    logic pr_valid_reg;
    tlik_pkg::cordic_bus_t pr_bus_reg, pr_bus_next;
    logic signed [tlik_pkg::CW-1:0] ox [tlik_pkg::LANES];
    logic signed [tlik_pkg::CW-1:0] oy [tlik_pkg::LANES];

    always_comb
    begin
        ox[0] = tlik_pkg::CW'(k4_side_reg.c);
        oy[0] = tlik_pkg::CW'(k4_s_reg);
        ox[1] = tlik_pkg::CW'(x1_reg);
        oy[1] = tlik_pkg::CW'(y1_reg);
        ox[2] = tlik_pkg::CW'(x2_reg);
        oy[2] = tlik_pkg::CW'(y2_reg);
        pr_bus_next.status = k4_side_reg.status;
        for (int l = 0; l < tlik_pkg::LANES; l++)
        begin
            pr_bus_next.lane[l].zero = (ox[l] == '0) && (oy[l] == '0);
            if (!ox[l][tlik_pkg::CW-1])
            begin
                pr_bus_next.lane[l].x = ox[l];
                pr_bus_next.lane[l].y = oy[l];
                pr_bus_next.lane[l].z = '0;
            end
            else if (!oy[l][tlik_pkg::CW-1])
            begin
                pr_bus_next.lane[l].x = oy[l];
                pr_bus_next.lane[l].y = -ox[l];
                pr_bus_next.lane[l].z = tlik_pkg::HALF_PI_Q30;
            end
            else
            begin
                pr_bus_next.lane[l].x = -oy[l];
                pr_bus_next.lane[l].y = ox[l];
                pr_bus_next.lane[l].z = -tlik_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pr_valid_reg <= k4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_bus_reg <= pr_bus_next;
        end
    end

    // ---------------- CORDIC chain ----------------
    logic                  cd_valid [tlik_pkg::CORDIC_STAGES+1];
    tlik_pkg::cordic_bus_t cd_bus   [tlik_pkg::CORDIC_STAGES+1];

    assign cd_valid[0] = pr_valid_reg;
    assign cd_bus[0]   = pr_bus_reg;

    for (genvar k = 0; k < tlik_pkg::CORDIC_STAGES; k++)
    begin : g_cordic
        tlik_cordic_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .stage      (5'(k)),
            .prev_valid (cd_valid[k]),
            .prev_bus   (cd_bus[k]),
            .valid_reg  (cd_valid[k+1]),
            .bus_reg    (cd_bus[k+1])
        );
    end

    // ---------------- rounding, limits, result ----------------
    tlik_pkg::cordic_bus_t fin;
    tlik_pkg::result_t     result_reg, result_next;
    logic signed [tlik_pkg::ZW-1:0] zr [tlik_pkg::LANES];
    logic signed [16:0] ang [tlik_pkg::LANES];
    logic signed [16:0] e2;
    logic signed [16:0] sh_lim, el_lim;
    logic in1, in2;

    assign fin = cd_bus[tlik_pkg::CORDIC_STAGES];

    always_comb
    begin
        for (int l = 0; l < tlik_pkg::LANES; l++)
        begin
            zr[l]  = fin.lane[l].z + 34'sd65536;
            ang[l] = fin.lane[l].zero ? 17'sd0 : $signed(zr[l][33:17]);
        end
        e2     = -ang[0];
        sh_lim = $signed({2'b00, shoulder_reg});
        el_lim = $signed({2'b00, elbow_reg});
        in1 = (ang[1] >= -sh_lim) && (ang[1] <= sh_lim)
           && (ang[0] >= -el_lim) && (ang[0] <= el_lim);
        in2 = (ang[2] >= -sh_lim) && (ang[2] <= sh_lim)
           && (e2 >= -el_lim) && (e2 <= el_lim);
        result_next = '0;
        result_next.reach_status = fin.status;
        if (fin.status == tlik_pkg::REACH_OK)
        begin
            result_next.first_valid     = in1;
            result_next.first_shoulder  = ang[1][15:0];
            result_next.first_elbow     = ang[0][15:0];
            result_next.second_valid    = in2;
            result_next.second_shoulder = ang[2][15:0];
            result_next.second_elbow    = e2[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cd_valid[tlik_pkg::CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    // ---------------- assertions ----------------
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reach_status != tlik_pkg::REACH_OK |->
            !result.first_valid && !result.second_valid
            && result.first_shoulder == '0 && result.first_elbow == '0
            && result.second_shoulder == '0 && result.second_elbow == '0)
        else $error("unreachable result carries angles");

    a_elbow_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reach_status == tlik_pkg::REACH_OK |->
            result.second_elbow == -result.first_elbow && !result.first_elbow[15])
        else $error("elbow solutions are not a mirrored pair");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && !target_stall |=> s1_valid_reg)
        else $error("request lost between front stages");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(s3_valid_reg))
        else $error("pipeline moved while result was held");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Two-link inverse kinematics core testbench
// Drives target points through the valid/stall channel, predicts every
// result with an independent fixed-point solver, and checks each result
// field by field across several link and joint limit settings.
// ============================================================================
module tb;

    localparam int     LIMIT_CYCLES = 1000000;
    localparam int     DRAIN_CYCLES = 70;
    localparam longint SAT47        = longint'(1) << 47;
    localparam longint HALF_PI_Z    = 1686629713;
    localparam longint ATAN_TAB [0:15] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    logic              clk;
    logic              rst_n;
    logic              target_valid;
    logic              target_stall;
    tlik_pkg::target_t target;
    logic              result_valid;
    logic              result_stall;
    tlik_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Working copy of the register file for the solver.
    logic [14:0] link1_q;
    logic [14:0] link2_q;
    logic [14:0] shoulder_lim_q;
    logic [14:0] elbow_lim_q;

    tlik_pkg::target_t pending_targets [$];
    tlik_pkg::result_t expected_poses [$];

    int  mismatches;
    int  cycles;
    int  gap_left;
    int  hold_left;
    int  hold_requests;
    int  hold_served;
    bit  no_idle;
    bit  took;
    int  results_seen;
    int  reach_count [3];
    int  valid_count;
    int  settings_run;

    two_link_planar_inverse_kinematics_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .target       (target),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint root_floor(input longint a);
        longint res;
        longint bitv;
        res  = 0;
        bitv = longint'(1) << 28;
        while (bitv > a)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (a >= res + bitv)
            begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring-mode arctangent, Q.30 radians.
    function automatic longint vector_angle(input longint yy, input longint xx);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (xx == 0 && yy == 0)
            return 0;
        while (mag64(xx) >= SAT47 || mag64(yy) >= SAT47)
        begin
            xx = xx >>> 1;
            yy = yy >>> 1;
        end
        if (xx < 0)
        begin
            if (yy >= 0)
            begin
                t = yy; yy = -xx; xx = t; z = HALF_PI_Z;
            end
            else
            begin
                t = -yy; yy = xx; xx = t; z = -HALF_PI_Z;
            end
        end
        for (int i = 0; i < tlik_pkg::CORDIC_STAGES; i++)
        begin
            xs = xx >>> i;
            ys = yy >>> i;
            if (yy >= 0)
            begin
                xx = xx + ys; yy = yy - xs; z = z + ATAN_TAB[i];
            end
            else
            begin
                xx = xx - ys; yy = yy + xs; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(input longint z);
        return (z + (longint'(1) << 16)) >>> 17;
    endfunction

    function automatic bit in_band(input longint a, input longint lim);
        return (a >= -lim) && (a <= lim);
    endfunction

    function automatic tlik_pkg::result_t solve_pose(input tlik_pkg::target_t tg);
        tlik_pkg::result_t r;
        longint  x, y, r2, d1, d2, reach, diff, num, den, q, c, s;
        longint  k1, ks, e1, e2, sh1, sh2;
        r  = '0;
        x  = tg.target_x;
        y  = tg.target_y;
        d1 = link1_q;
        d2 = link2_q;
        r2 = x * x + y * y;
        reach = (d1 + d2) * (d1 + d2);
        diff  = mag64(d1 - d2);
        if (r2 > reach)
        begin
            r.reach_status = tlik_pkg::REACH_FAR;
            return r;
        end
        if (r2 < diff * diff)
        begin
            r.reach_status = tlik_pkg::REACH_NEAR;
            return r;
        end
        num = r2 - (d1 * d1 + d2 * d2);
        den = 2 * d1 * d2;
        if (den == 0)
        begin
            c = 16384;
        end
        else
        begin
            q = (mag64(num) << 14) / den;
            if (q > 16384)
                q = 16384;
            c = (num < 0) ? -q : q;
        end
        s   = root_floor((longint'(1) << 28) - c * c);
        e1  = round_angle(vector_angle(s, c));
        e2  = -e1;
        k1  = d1 * 16384 + d2 * c;
        ks  = d2 * s;
        sh1 = round_angle(vector_angle(y * k1 - x * ks, x * k1 + y * ks));
        sh2 = round_angle(vector_angle(y * k1 + x * ks, x * k1 - y * ks));
        r.reach_status    = tlik_pkg::REACH_OK;
        r.first_valid     = in_band(sh1, shoulder_lim_q) && in_band(e1, elbow_lim_q);
        r.first_shoulder  = sh1[15:0];
        r.first_elbow     = e1[15:0];
        r.second_valid    = in_band(sh2, shoulder_lim_q) && in_band(e2, elbow_lim_q);
        r.second_shoulder = sh2[15:0];
        r.second_elbow    = e2[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        mismatches++;
    endtask

    task automatic check_pose(input tlik_pkg::result_t got, input tlik_pkg::result_t want);
        if (got.reach_status !== want.reach_status)
            report_mismatch("reach_status", got.reach_status, want.reach_status);
        if (got.first_valid !== want.first_valid)
            report_mismatch("first_valid", got.first_valid, want.first_valid);
        if (got.first_shoulder !== want.first_shoulder)
            report_mismatch("first_shoulder", got.first_shoulder, want.first_shoulder);
        if (got.first_elbow !== want.first_elbow)
            report_mismatch("first_elbow", got.first_elbow, want.first_elbow);
        if (got.second_valid !== want.second_valid)
            report_mismatch("second_valid", got.second_valid, want.second_valid);
        if (got.second_shoulder !== want.second_shoulder)
            report_mismatch("second_shoulder", got.second_shoulder, want.second_shoulder);
        if (got.second_elbow !== want.second_elbow)
            report_mismatch("second_elbow", got.second_elbow, want.second_elbow);
    endtask

    function automatic int pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // Sender: holds a stalled request, otherwise idles or offers the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (target_valid && !took)
            begin
                target_valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                target_valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (pending_targets.size() > 0)
            begin
                target       <= pending_targets.pop_front();
                target_valid <= 1'b1;
                gap_left     <= pick_gap();
            end
            else
            begin
                target_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served  <= hold_requests;
                hold_left    <= 400;
                result_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (no_idle)
            begin
                result_stall <= 1'b0;
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                result_stall <= ($urandom_range(0, 3) == 0);
            end
            else
            begin
                result_stall <= 1'b1;
                hold_left    <= $urandom_range(5, 40);
            end
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results.
    always @(posedge clk)
    begin
        tlik_pkg::result_t want;
        took <= target_valid && !target_stall;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb: FAIL");
                $finish;
            end
            if (target_valid && !target_stall)
                expected_poses = {expected_poses, solve_pose(target)};
            if (result_valid && !result_stall)
            begin
                if (expected_poses.size() == 0)
                begin
                    report_mismatch("result with no request", 1, 0);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    check_pose(result, want);
                    results_seen++;
                    if (want.reach_status < 3)
                        reach_count[want.reach_status]++;
                    if (want.first_valid || want.second_valid)
                        valid_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {17'($urandom_range(0, 131071)), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tlik_pkg::REG_LINK1:    link1_q        = val;
            tlik_pkg::REG_LINK2:    link2_q        = val;
            tlik_pkg::REG_SHOULDER: shoulder_lim_q = val;
            default:                elbow_lim_q    = val;
        endcase
    endtask

    task automatic set_arm(input int l1, input int l2, input int sl, input int el);
        write_reg(tlik_pkg::REG_LINK1, 15'(l1));
        write_reg(tlik_pkg::REG_LINK2, 15'(l2));
        write_reg(tlik_pkg::REG_SHOULDER, 15'(sl));
        write_reg(tlik_pkg::REG_ELBOW, 15'(el));
        settings_run++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_targets.size() != 0 || target_valid || expected_poses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_point(input int x, input int y);
        tlik_pkg::target_t t;
        t.target_x = 16'(x);
        t.target_y = 16'(y);
        pending_targets = {pending_targets, t};
    endtask

    // Mostly points around the reach annulus, the rest anywhere in the plane.
    task automatic queue_random(input int count);
        int reach;
        int x;
        int y;
        for (int i = 0; i < count; i++)
        begin
            reach = link1_q + link2_q + 8;
            if (reach > 32767)
                reach = 32767;
            if ($urandom_range(0, 9) < 7)
            begin
                x = int'($urandom_range(0, 2 * reach)) - reach;
                y = int'($urandom_range(0, 2 * reach)) - reach;
            end
            else
            begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 65535)) - 32768;
            end
            queue_point(x, y);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        target_valid  = 1'b0;
        target        = '0;
        result_stall  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        took          = 1'b0;
        no_idle       = 1'b0;
        gap_left      = 0;
        hold_left     = 0;
        hold_requests = 0;
        hold_served   = 0;
        mismatches    = 0;
        cycles        = 0;
        results_seen  = 0;
        valid_count   = 0;
        settings_run  = 1;
        reach_count   = '{0, 0, 0};
        link1_q        = 4096;
        link2_q        = 4096;
        shoulder_lim_q = 19302;
        elbow_lim_q    = 19302;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points under the reset arm: base, the reach circle, corners.
        queue_point(0, 0);
        queue_point(8192, 0);
        queue_point(8193, 0);
        queue_point(-8192, 0);
        queue_point(0, -8192);
        queue_point(0, 8192);
        queue_point(-4096, -4096);
        queue_point(-4096, 4096);
        queue_point(4096, -1);
        queue_point(32767, 32767);
        queue_point(-32768, -32768);
        queue_point(-32768, 32767);
        queue_point(1, 0);
        queue_point(-1, -1);
        wait_drained();

        // Unequal links: the inner circle and points too close to the base.
        set_arm(6000, 2000, 25736, 25736);
        queue_point(0, 0);
        queue_point(4000, 0);
        queue_point(3999, 0);
        queue_point(-8000, 0);
        queue_point(0, -4000);
        wait_drained();

        // Zero link length, zero limits.
        set_arm(0, 4096, 0, 0);
        queue_point(0, 4096);
        queue_point(-4096, 0);
        queue_point(0, 0);
        queue_random(60);
        wait_drained();

        // Longest links and all-ones limit registers; the sender never idles
        // while the receiver holds off long enough to back the pipeline up.
        set_arm(32767, 32767, 32767, 32767);
        no_idle = 1'b1;
        hold_requests++;
        queue_random(300);
        wait_drained();
        no_idle = 1'b0;

        set_arm(1, 3000, 12000, 5000);
        queue_random(200);
        wait_drained();

        set_arm(4096, 4096, 19302, 19302);
        queue_random(250);
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            set_arm($urandom_range(0, 20000), $urandom_range(0, 20000),
                    $urandom_range(0, 25736), $urandom_range(0, 25736));
            queue_random(130);
            wait_drained();
        end

        $display("tb: %0d results over %0d arm settings, %0d with a valid solution",
                 results_seen, settings_run, valid_count);
        $display("tb: reachable %0d, too far %0d, too close %0d",
                 reach_count[0], reach_count[1], reach_count[2]);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
